/* hw/rtl/qpgm_pkg.sv */
package qpgm_pkg;

  localparam int CW       = 32;             // coordinate width taken from each field
  localparam int FW       = 32;             // field width on the ports
  localparam int DW       = CW + 1;         // vertex difference
  localparam int CHW      = CW + 2;         // chord vector sum
  localparam int PW       = 2 * DW;         // one cross partial product
  localparam int XW       = PW + 1;         // cross component
  localparam int LZW      = $clog2(XW + 1);
  localparam int NB       = 31;             // normalized magnitude bits
  localparam int SW       = $clog2(XW - NB + 1);
  localparam int SQW      = 2 * NB + 2;     // sum of three squares
  localparam int RTW      = SQW / 2;        // square root width, one stage per bit
  localparam int FRAC_N   = 30;             // Q1.30 normal
  localparam int NW       = NB + FRAC_N + 1;
  localparam int QW       = NB;             // quotient bits, one stage per bit
  localparam int CFW      = 17;
  localparam logic [CFW-1:0] CF_RESET = 17'd32768;
  localparam int CPW      = CHW + CFW + 1;
  localparam int COL_FRAC = 16;
  localparam int COL_SH   = 17;
  localparam int COL_RND  = 65536;
  localparam int NUMW     = CPW + 2;
  localparam int SHW      = NUMW - COL_SH;
  localparam int LAW      = RTW + (XW - NB);
  localparam int AREA_SH  = 17;
  localparam int AHW      = LAW + 1 - AREA_SH;
  localparam int AW       = 48;
  localparam int NST      = 7 + RTW + 1 + QW + 1;

  typedef struct packed {
    logic signed [FW-1:0] v0_x;
    logic signed [FW-1:0] v0_y;
    logic signed [FW-1:0] v0_z;
    logic signed [FW-1:0] v1_x;
    logic signed [FW-1:0] v1_y;
    logic signed [FW-1:0] v1_z;
    logic signed [FW-1:0] v2_x;
    logic signed [FW-1:0] v2_y;
    logic signed [FW-1:0] v2_z;
    logic signed [FW-1:0] v3_x;
    logic signed [FW-1:0] v3_y;
    logic signed [FW-1:0] v3_z;
  } panel_in_t;

  typedef struct packed {
    logic signed [FW-1:0] normal_x;
    logic signed [FW-1:0] normal_y;
    logic signed [FW-1:0] normal_z;
    logic [AW-1:0]        panel_area;
    logic signed [FW-1:0] colloc_x;
    logic signed [FW-1:0] colloc_y;
    logic signed [FW-1:0] colloc_z;
    logic                 degenerate;
  } panel_out_t;

  // per-item results that ride along the pipeline from the cross products to the output
  typedef struct packed {
    logic [2:0][FW-1:0] colloc;
    logic [2:0]         sgn;
    logic               deg;
    logic [AW-1:0]      area;
  } side_t;

  // values needed only until the square roots are done
  typedef struct packed {
    logic [2:0][NB-1:0] rn;
    logic [1:0][SW-1:0] sa;
  } mid_t;

endpackage

/* hw/rtl/qpgm_isqrt.sv */
module qpgm_isqrt
  import qpgm_pkg::*;
(
  input  logic           clk,
  input  logic           en,
  input  logic [SQW-1:0] sum_i,
  output logic [RTW-1:0] root_o
);

  logic [SQW-1:0] rem_r   [RTW];
  logic [SQW-1:0] res_r   [RTW];
  logic [SQW-1:0] rem_nxt [RTW];
  logic [SQW-1:0] res_nxt [RTW];
  logic [SQW-1:0] rin     [RTW];
  logic [SQW-1:0] resin   [RTW];
  logic [SQW-1:0] bitv    [RTW];
  logic [SQW-1:0] trial   [RTW];

  // one result bit per stage, digit by digit
  always_comb begin
    for (int j = 0; j < RTW; j++) begin
      rin[j]   = (j == 0) ? sum_i : rem_r[(j == 0) ? 0 : j - 1];
      resin[j] = (j == 0) ? '0 : res_r[(j == 0) ? 0 : j - 1];
      bitv[j]  = SQW'(1) << (SQW - 2 - 2 * j);
      trial[j] = resin[j] + bitv[j];
      if (rin[j] >= trial[j]) begin
        rem_nxt[j] = rin[j] - trial[j];
        res_nxt[j] = (resin[j] >> 1) + bitv[j];
      end else begin
        rem_nxt[j] = rin[j];
        res_nxt[j] = resin[j] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < RTW; j++) begin
        rem_r[j] <= rem_nxt[j];
        res_r[j] <= res_nxt[j];
      end
    end
  end

  assign root_o = res_r[RTW-1][RTW-1:0];

endmodule

/* hw/rtl/qpgm_div.sv */
module qpgm_div
  import qpgm_pkg::*;
(
  input  logic           clk,
  input  logic           en,
  input  logic [NW-1:0]  num_i,
  input  logic [RTW-1:0] den_i,
  output logic [QW-1:0]  quo_o
);

  logic [RTW-1:0] rem_r   [QW];
  logic [NW-1:0]  num_r   [QW];
  logic [RTW-1:0] den_r   [QW];
  logic [QW-1:0]  q_r     [QW];
  logic [RTW-1:0] rem_nxt [QW];
  logic [QW-1:0]  q_nxt   [QW];
  logic [RTW-1:0] rin     [QW];
  logic [NW-1:0]  nin     [QW];
  logic [RTW-1:0] din     [QW];
  logic [QW-1:0]  qin     [QW];
  logic [RTW:0]   t       [QW];

  // restoring division, one quotient bit per stage; quotient fits QW bits
  always_comb begin
    for (int j = 0; j < QW; j++) begin
      rin[j] = (j == 0) ? RTW'(num_i[NW-1:QW]) : rem_r[(j == 0) ? 0 : j - 1];
      nin[j] = (j == 0) ? num_i : num_r[(j == 0) ? 0 : j - 1];
      din[j] = (j == 0) ? den_i : den_r[(j == 0) ? 0 : j - 1];
      qin[j] = (j == 0) ? '0 : q_r[(j == 0) ? 0 : j - 1];
      t[j]   = {rin[j], nin[j][QW-1-j]};
      q_nxt[j] = qin[j];
      if (t[j] >= {1'b0, din[j]}) begin
        rem_nxt[j]         = RTW'(t[j] - {1'b0, din[j]});
        q_nxt[j][QW-1-j]   = 1'b1;
      end else begin
        rem_nxt[j] = t[j][RTW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < QW; j++) begin
        rem_r[j] <= rem_nxt[j];
        num_r[j] <= nin[j];
        den_r[j] <= din[j];
        q_r[j]   <= q_nxt[j];
      end
    end
  end

  assign quo_o = q_r[QW-1];

endmodule

/* hw/rtl/quad_panel_geometry_metrics.sv */
// Quadrilateral panel geometry unit.
// Input channel in_valid/in_ready/in_data carries the four corners of one panel
// (v0 upper left, v1 upper right, v2 lower right, v3 lower left, Q16.16).
// Output channel out_valid/out_ready/out_data returns one result per panel:
// unit normal (Q1.30), area (Q32.16, saturating), collocation point (Q16.16,
// saturating) and a degenerate flag when the diagonal cross product is zero.
// cfg_we/cfg_wdata write the chord factor (unsigned Q1.16); write it only while
// no panel is in flight.
// From input transfer to result valid the panel passes differences, cross
// products, normalization and squares, then square root (one bit per stage),
// area and numerator, division for the normal (one quotient bit per stage)
// and the output register. Throughput is one panel per cycle unless the
// receiver stalls.
// Reset clears all valid bits and sets the chord factor to 0.5.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_ready drops; the pipeline advances whenever the output holds no result.
module quad_panel_geometry_metrics
  import qpgm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  panel_in_t        in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output panel_out_t       out_data,
  input  logic             cfg_we,
  input  logic [CFW-1:0]   cfg_wdata
);

  function automatic logic [LZW-1:0] lzc(input logic [XW-1:0] v);
    logic [LZW-1:0] n;
    n = LZW'(XW);
    for (int i = 0; i < XW; i++) begin
      if (v[i]) n = LZW'(XW - 1 - i);
    end
    return n;
  endfunction

  function automatic logic [FW-1:0] sat32(input logic [SHW-1:0] v);
    logic hi_same;
    hi_same = (&v[SHW-1:FW-1]) | ~(|v[SHW-1:FW-1]);
    if (hi_same) return v[FW-1:0];
    return v[SHW-1] ? {1'b1, {(FW-1){1'b0}}} : {1'b0, {(FW-1){1'b1}}};
  endfunction

  logic            en;
  logic [NST-1:0]  v_r;
  logic [CFW-1:0]  cf_r;

  assign en        = ~v_r[NST-1] | out_ready;
  assign in_ready  = en;
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      cf_r <= CF_RESET;
    end else begin
      if (en) v_r <= {v_r[NST-2:0], in_valid};
      if (cfg_we) cf_r <= cfg_wdata;
    end
  end

  // stage 1: coordinates and differences
  logic signed [CW-1:0] c0 [3], c1 [3], c2 [3], c3 [3];
  assign c0[0] = in_data.v0_x[CW-1:0];
  assign c0[1] = in_data.v0_y[CW-1:0];
  assign c0[2] = in_data.v0_z[CW-1:0];
  assign c1[0] = in_data.v1_x[CW-1:0];
  assign c1[1] = in_data.v1_y[CW-1:0];
  assign c1[2] = in_data.v1_z[CW-1:0];
  assign c2[0] = in_data.v2_x[CW-1:0];
  assign c2[1] = in_data.v2_y[CW-1:0];
  assign c2[2] = in_data.v2_z[CW-1:0];
  assign c3[0] = in_data.v3_x[CW-1:0];
  assign c3[1] = in_data.v3_y[CW-1:0];
  assign c3[2] = in_data.v3_z[CW-1:0];

  logic signed [DW-1:0]  d1_r [3], d2_r [3], f_r [3], e_r [3], s01_r [3];
  logic signed [CHW-1:0] ch_r [3];

  // stage 2: partial products
  logic signed [DW-1:0]  ua [3][3], ub [3][3];
  logic signed [PW-1:0]  pa_r [3][3], pb_r [3][3];
  logic signed [CPW-1:0] cp_r [3];
  logic signed [DW-1:0]  s01b_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ua[0][i] = d1_r[i];
      ub[0][i] = d2_r[i];
      ua[1][i] = f_r[i];
      ub[1][i] = d2_r[i];
      ua[2][i] = d2_r[i];
      ub[2][i] = e_r[i];
    end
  end

  // stage 3: cross components, magnitudes, collocation point
  logic signed [XW-1:0]   cr [3][3];
  logic [XW-1:0]          m3_r [3][3];
  logic signed [NUMW-1:0] num [3];
  side_t                  side3_nxt, side3_r;

  always_comb begin
    side3_nxt = '0;
    for (int x = 0; x < 3; x++) begin
      for (int i = 0; i < 3; i++) begin
        cr[x][i] = XW'(pa_r[x][i]) - XW'(pb_r[x][i]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      num[i] = (NUMW'(s01b_r[i]) <<< COL_FRAC) + NUMW'(cp_r[i]) + NUMW'(COL_RND);
      side3_nxt.colloc[i] = sat32(num[i][NUMW-1:COL_SH]);
      side3_nxt.sgn[i]    = cr[0][i][XW-1];
    end
  end

  // stage 4: leading zeros of the largest magnitude
  logic [XW-1:0]  m4_r [3][3];
  logic [LZW-1:0] lz4_r [3];
  logic [XW-1:0]  mor [3];
  side_t          side4_nxt, side4_r;

  always_comb begin
    for (int x = 0; x < 3; x++) begin
      mor[x] = m3_r[x][0] | m3_r[x][1] | m3_r[x][2];
    end
    side4_nxt     = side3_r;
    side4_nxt.deg = ~(|mor[0]);
  end

  // stage 5: normalize
  logic [XW-1:0]  shn [3];
  logic [SW-1:0]  sa [3];
  logic [NB-1:0]  r5_nxt [3][3];
  logic [NB-1:0]  r5_r [3][3];
  side_t          side5_r;
  mid_t           mid5_nxt, mid5_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shn[i]       = m4_r[0][i] << lz4_r[0];
      r5_nxt[0][i] = shn[i][XW-1 -: NB];
    end
    for (int x = 0; x < 3; x++) begin
      if (lz4_r[x] < LZW'(XW - NB)) sa[x] = SW'(LZW'(XW - NB) - lz4_r[x]);
      else sa[x] = '0;
    end
    for (int x = 1; x < 3; x++) begin
      for (int i = 0; i < 3; i++) begin
        r5_nxt[x][i] = NB'(m4_r[x][i] >> sa[x]);
      end
    end
    for (int i = 0; i < 3; i++) mid5_nxt.rn[i] = r5_nxt[0][i];
    mid5_nxt.sa[0] = sa[1];
    mid5_nxt.sa[1] = sa[2];
  end

  // stages 6 and 7: squares and their sums
  logic [2*NB-1:0] sq6_r [3][3];
  logic [SQW-1:0]  sum7_r [3];
  side_t           side6_r, side7_r;
  mid_t            mid6_r, mid7_r;

  // square root segment
  side_t           side_sq_r [RTW];
  mid_t            mid_sq_r [RTW];
  logic [RTW-1:0]  root [3];

  // stage after the roots: area and division numerator
  logic [LAW-1:0]  la1, la2;
  logic [LAW:0]    asum;
  logic [AHW-1:0]  ah;
  side_t           side40_nxt, side40_r;
  logic [NW-1:0]   n40_nxt [3];
  logic [NW-1:0]   n40_r [3];
  logic [RTW-1:0]  len40_r;

  always_comb begin
    la1  = LAW'(root[1]) << mid_sq_r[RTW-1].sa[0];
    la2  = LAW'(root[2]) << mid_sq_r[RTW-1].sa[1];
    asum = (LAW+1)'(la1) + (LAW+1)'(la2);
    ah   = asum[LAW:AREA_SH];
    side40_nxt      = side_sq_r[RTW-1];
    side40_nxt.area = (|ah[AHW-1:AW]) ? {AW{1'b1}} : ah[AW-1:0];
    for (int i = 0; i < 3; i++) begin
      n40_nxt[i] = (NW'(mid_sq_r[RTW-1].rn[i]) << FRAC_N) + NW'(root[0] >> 1);
    end
  end

  // division segment and output
  side_t           side_dv_r [QW];
  logic [QW-1:0]   quo [3];
  logic [FW-1:0]   nrm [3];
  panel_out_t      out_nxt, out_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (side_dv_r[QW-1].deg) nrm[i] = '0;
      else if (side_dv_r[QW-1].sgn[i]) nrm[i] = -FW'(quo[i]);
      else nrm[i] = FW'(quo[i]);
    end
    out_nxt.normal_x   = nrm[0];
    out_nxt.normal_y   = nrm[1];
    out_nxt.normal_z   = nrm[2];
    out_nxt.panel_area = side_dv_r[QW-1].area;
    out_nxt.colloc_x   = side_dv_r[QW-1].colloc[0];
    out_nxt.colloc_y   = side_dv_r[QW-1].colloc[1];
    out_nxt.colloc_z   = side_dv_r[QW-1].colloc[2];
    out_nxt.degenerate = side_dv_r[QW-1].deg;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_r[i]  <= DW'(c3[i]) - DW'(c1[i]);
        d2_r[i]  <= DW'(c2[i]) - DW'(c0[i]);
        f_r[i]   <= DW'(c3[i]) - DW'(c0[i]);
        e_r[i]   <= DW'(c1[i]) - DW'(c0[i]);
        s01_r[i] <= DW'(c0[i]) + DW'(c1[i]);
        ch_r[i]  <= CHW'(c2[i]) + CHW'(c3[i]) - CHW'(c0[i]) - CHW'(c1[i]);
      end
      for (int x = 0; x < 3; x++) begin
        for (int i = 0; i < 3; i++) begin
          pa_r[x][i] <= ua[x][(i + 1) % 3] * ub[x][(i + 2) % 3];
          pb_r[x][i] <= ua[x][(i + 2) % 3] * ub[x][(i + 1) % 3];
          m3_r[x][i] <= cr[x][i][XW-1] ? -cr[x][i] : cr[x][i];
          m4_r[x][i] <= m3_r[x][i];
          r5_r[x][i] <= r5_nxt[x][i];
          sq6_r[x][i] <= r5_r[x][i] * r5_r[x][i];
        end
        lz4_r[x]  <= lzc(mor[x]);
        sum7_r[x] <= SQW'(sq6_r[x][0]) + SQW'(sq6_r[x][1]) + SQW'(sq6_r[x][2]);
      end
      for (int i = 0; i < 3; i++) begin
        cp_r[i]   <= ch_r[i] * $signed({1'b0, cf_r});
        s01b_r[i] <= s01_r[i];
      end
      side3_r <= side3_nxt;
      side4_r <= side4_nxt;
      side5_r <= side4_r;
      mid5_r  <= mid5_nxt;
      side6_r <= side5_r;
      mid6_r  <= mid5_r;
      side7_r <= side6_r;
      mid7_r  <= mid6_r;
      side_sq_r[0] <= side7_r;
      mid_sq_r[0]  <= mid7_r;
      for (int k = 1; k < RTW; k++) begin
        side_sq_r[k] <= side_sq_r[k-1];
        mid_sq_r[k]  <= mid_sq_r[k-1];
      end
      side40_r <= side40_nxt;
      len40_r  <= root[0];
      for (int i = 0; i < 3; i++) n40_r[i] <= n40_nxt[i];
      side_dv_r[0] <= side40_r;
      for (int k = 1; k < QW; k++) side_dv_r[k] <= side_dv_r[k-1];
      out_r <= out_nxt;
    end
  end

  for (genvar x = 0; x < 3; x++) begin : g_sqrt
    qpgm_isqrt u_isqrt (
      .clk    (clk),
      .en     (en),
      .sum_i  (sum7_r[x]),
      .root_o (root[x])
    );
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    qpgm_div u_div (
      .clk   (clk),
      .en    (en),
      .num_i (n40_r[i]),
      .den_i (len40_r),
      .quo_o (quo[i])
    );
  end

  assign out_data = out_r;

endmodule

/* test/qpgm_checker.sv */
module qpgm_checker
  import qpgm_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  panel_in_t      in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  panel_out_t     out_data,
  input  logic           cfg_we,
  input  logic [CFW-1:0] cfg_wdata,
  output int             errors,
  output int             pending
);

  typedef logic signed [127:0] wide_t;

  logic [CFW-1:0] factor;
  panel_out_t     metrics_q[$];

  assign pending = metrics_q.size();

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res, bitv;
    res  = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic int unsigned bit_len(wide_t m);
    for (int i = 127; i >= 0; i--)
      if (m[i]) return i + 1;
    return 0;
  endfunction

  function automatic wide_t magn(wide_t c);
    return (c < 0) ? -c : c;
  endfunction

  function automatic void cross3(input wide_t a[3], input wide_t b[3], output wide_t c[3]);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // largest component cut to 31 bits, length scaled back up
  function automatic wide_t tri_len(wide_t c[3]);
    int unsigned bl, s;
    logic [63:0] sum, r;
    bl  = 0;
    sum = 0;
    for (int i = 0; i < 3; i++)
      if (bit_len(magn(c[i])) > bl) bl = bit_len(magn(c[i]));
    s = (bl > 31) ? bl - 31 : 0;
    for (int i = 0; i < 3; i++) begin
      r   = 64'(magn(c[i]) >> s);
      sum = sum + r * r;
    end
    return wide_t'(root64(sum)) << s;
  endfunction

  function automatic panel_out_t panel_metrics(panel_in_t p, logic [CFW-1:0] cf);
    wide_t v[4][3];
    wide_t d1[3], d2[3], f[3], b[3], e[3], c[3];
    wide_t area, num, q, cfw;
    logic [63:0] r[3];
    logic [63:0] sum, len, qn;
    logic [31:0] col[3];
    int unsigned bl;
    panel_out_t o;
    v[0][0] = p.v0_x; v[0][1] = p.v0_y; v[0][2] = p.v0_z;
    v[1][0] = p.v1_x; v[1][1] = p.v1_y; v[1][2] = p.v1_z;
    v[2][0] = p.v2_x; v[2][1] = p.v2_y; v[2][2] = p.v2_z;
    v[3][0] = p.v3_x; v[3][1] = p.v3_y; v[3][2] = p.v3_z;
    for (int i = 0; i < 3; i++) begin
      d1[i] = v[3][i] - v[1][i];
      d2[i] = v[2][i] - v[0][i];
      f[i]  = v[3][i] - v[0][i];
      b[i]  = v[2][i] - v[0][i];
      e[i]  = v[1][i] - v[0][i];
    end
    o = '0;
    cross3(d1, d2, c);
    bl = 0;
    for (int i = 0; i < 3; i++)
      if (bit_len(magn(c[i])) > bl) bl = bit_len(magn(c[i]));
    if (bl == 0) begin
      o.degenerate = 1'b1;
    end else begin
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        r[i] = (bl > 31) ? 64'(magn(c[i]) >> (bl - 31)) : 64'(magn(c[i]) << (31 - bl));
        sum  = sum + r[i] * r[i];
      end
      len = root64(sum);
      for (int i = 0; i < 3; i++) begin
        qn = ((r[i] << 30) + (len >> 1)) / len;
        if (c[i] < 0) qn = -qn;
        case (i)
          0: o.normal_x = qn[31:0];
          1: o.normal_y = qn[31:0];
          default: o.normal_z = qn[31:0];
        endcase
      end
    end
    cross3(f, b, c);
    area = tri_len(c);
    cross3(b, e, c);
    area = (area + tri_len(c)) >> 17;
    o.panel_area = (area > wide_t'(48'hFFFF_FFFF_FFFF)) ? 48'hFFFF_FFFF_FFFF : area[47:0];
    cfw = wide_t'({1'b0, cf});
    for (int i = 0; i < 3; i++) begin
      num = (v[0][i] + v[1][i]) * 65536
            + (v[2][i] + v[3][i] - v[0][i] - v[1][i]) * cfw + 65536;
      q = num >>> 17;
      if (q > 128'sd2147483647) col[i] = 32'h7FFF_FFFF;
      else if (q < -128'sd2147483648) col[i] = 32'h8000_0000;
      else col[i] = q[31:0];
    end
    o.colloc_x = col[0];
    o.colloc_y = col[1];
    o.colloc_z = col[2];
    return o;
  endfunction

  task automatic field_check(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    panel_out_t want;
    if (!rst_n) begin
      factor <= CF_RESET;
      errors = 0;
    end else begin
      if (cfg_we) factor <= cfg_wdata;
      if (in_valid && in_ready) metrics_q.push_back(panel_metrics(in_data, factor));
      if (out_valid && out_ready) begin
        if (metrics_q.size() == 0) begin
          $error("result transfer with no panel outstanding");
          errors++;
        end else begin
          want = metrics_q.pop_front();
          field_check("normal_x", 64'(want.normal_x), 64'(out_data.normal_x));
          field_check("normal_y", 64'(want.normal_y), 64'(out_data.normal_y));
          field_check("normal_z", 64'(want.normal_z), 64'(out_data.normal_z));
          field_check("panel_area", 64'(want.panel_area), 64'(out_data.panel_area));
          field_check("colloc_x", 64'(want.colloc_x), 64'(out_data.colloc_x));
          field_check("colloc_y", 64'(want.colloc_y), 64'(out_data.colloc_y));
          field_check("colloc_z", 64'(want.colloc_z), 64'(out_data.colloc_z));
          field_check("degenerate", 64'(want.degenerate), 64'(out_data.degenerate));
        end
      end
    end
  end

endmodule

/* test/tb_quad_panel_geometry_metrics.sv */
module tb_quad_panel_geometry_metrics;
  import qpgm_pkg::*;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  panel_in_t      in_data;
  logic           out_valid;
  logic           out_ready;
  panel_out_t     out_data;
  logic           cfg_we;
  logic [CFW-1:0] cfg_wdata;
  int             errors;
  int             pending;

  bit             quiet;
  int             stall_left;
  int             cycles;
  int             panels_sent;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int RANDOM_PER_PHASE = 388;

  quad_panel_geometry_metrics dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  qpgm_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stalls, mostly short
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (quiet || $urandom_range(0, 3) != 0) begin
      out_ready <= 1'b1;
    end else begin
      stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 90) : $urandom_range(0, 3);
      out_ready <= 1'b0;
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic panel_in_t pack_panel(logic [31:0] c[12]);
    return panel_in_t'({c[0], c[1], c[2], c[3], c[4], c[5],
                        c[6], c[7], c[8], c[9], c[10], c[11]});
  endfunction

  function automatic logic [31:0] near(logic [31:0] base, int unsigned span);
    return base + $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic panel_in_t rand_panel();
    logic [31:0] c[12];
    logic [31:0] base[3], d[3];
    logic [31:0] extremes[5];
    int unsigned mode;
    extremes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1};
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      base[i] = $urandom_range(0, 2 ** 21) - 2 ** 20;
      d[i]    = $urandom_range(0, 2 ** 17) - 2 ** 16;
    end
    for (int k = 0; k < 12; k++) begin
      case (mode)
        0, 1, 2, 3: c[k] = near(base[k % 3], 1 << 18);
        4, 5:       c[k] = $urandom;
        7:          c[k] = extremes[$urandom_range(0, 4)];
        default:    c[k] = $urandom_range(0, 2 ** 29) - 2 ** 28;
      endcase
    end
    // diagonals parallel: v2 = v0 + d, v3 = v1 + 2d
    if (mode == 6) begin
      for (int i = 0; i < 3; i++) begin
        c[i]     = near(base[i], 1 << 18);
        c[3 + i] = near(base[i], 1 << 18);
        c[6 + i] = c[i] + d[i];
        c[9 + i] = c[3 + i] + 2 * d[i];
      end
    end
    return pack_panel(c);
  endfunction

  task automatic send_panel(panel_in_t p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    panels_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  task automatic set_factor(logic [CFW-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_phase(int count);
    for (int n = 0; n < count; n++) begin
      quiet = (n >= count / 3 && n < count / 3 + 40);
      // hold until the pipeline has emptied once mid-phase
      if (n == count / 2) drain();
      send_panel(rand_panel());
    end
    quiet = 0;
  endtask

  task automatic directed_panels();
    logic [31:0] c[12];
    for (int k = 0; k < 12; k++) c[k] = 32'h0;
    send_panel(pack_panel(c));
    for (int k = 0; k < 12; k++) c[k] = 32'h7FFF_FFFF;
    send_panel(pack_panel(c));
    for (int k = 0; k < 12; k++) c[k] = 32'h8000_0000;
    send_panel(pack_panel(c));
    for (int k = 0; k < 12; k++)
      c[k] = (k < 3 || (k >= 6 && k < 9)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    send_panel(pack_panel(c));
    for (int k = 0; k < 12; k++) c[k] = (k % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
    send_panel(pack_panel(c));
    for (int k = 0; k < 12; k++) c[k] = (k < 6) ? 32'h7FFF_FFFF : 32'h8000_0000;
    send_panel(pack_panel(c));
    // unit square in the xy plane
    c = '{32'h0, 32'h1_0000, 32'h0, 32'h1_0000, 32'h1_0000, 32'h0,
          32'h1_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
    send_panel(pack_panel(c));
    // collinear corners along x
    c = '{32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h0, 32'h0,
          32'h3_0000, 32'h0, 32'h0, 32'h2_0000, 32'h0, 32'h0};
    send_panel(pack_panel(c));
    // square standing in the yz plane, negative side
    c = '{32'hFFFF_0000, 32'h0, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0, 32'h0,
          32'hFFFF_0000, 32'hFFFF_0000, 32'h0, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000};
    send_panel(pack_panel(c));
    // tiny panel, corners at most one LSB apart in each coordinate
    c = '{32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0,
          32'h1, 32'h1, 32'h0, 32'h0, 32'h1, 32'h1};
    send_panel(pack_panel(c));
    // huge panel spanning the full range
    c = '{32'h8000_0000, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0};
    send_panel(pack_panel(c));
    for (int k = 0; k < 12; k++) c[k] = 32'hFFFF_FFFF;
    send_panel(pack_panel(c));
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    quiet       = 0;
    panels_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_panels();
    random_phase(RANDOM_PER_PHASE);
    set_factor(17'd0);
    directed_panels();
    random_phase(RANDOM_PER_PHASE);
    set_factor(17'h1FFFF);
    directed_panels();
    random_phase(RANDOM_PER_PHASE);
    set_factor(CFW'($urandom_range(1, 131070)));
    random_phase(RANDOM_PER_PHASE);
    set_factor(17'd65536);
    random_phase(RANDOM_PER_PHASE);

    drain();
    $display("%0d panels transferred, chord factor at 0.5, 0, full scale, random and 1.0,",
             panels_sent);
    $display("with degenerate, extreme and saturating corners under random stalls");
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
